[hw/rtl/tfp_pkg.sv]
// Shared types, character codes and the key label for the text frame parser.
package tfp_pkg;

    // Parser phases
    typedef enum logic [2:0] {
        PH_IDLE  = 3'd0,
        PH_WAIT  = 3'd1,
        PH_LABEL = 3'd2,
        PH_VALUE = 3'd3,
        PH_HEX   = 3'd4,
        PH_CKSUM = 3'd5
    } phase_t;

    // Event codes on the result channel
    typedef enum logic [2:0] {
        EV_NONE    = 3'd0,
        EV_LCHAR   = 3'd1,
        EV_VSTART  = 3'd2,
        EV_VCHAR   = 3'd3,
        EV_FEND    = 3'd4,
        EV_OK      = 3'd5,
        EV_BAD     = 3'd6,
        EV_TIMEOUT = 3'd7
    } event_kind_t;

    // Input request kinds
    localparam logic REQ_BYTE = 1'b0;
    localparam logic REQ_TICK = 1'b1;

    // Characters the parser reacts to
    localparam logic [7:0] CHAR_COLON = 8'h3A;
    localparam logic [7:0] CHAR_CR    = 8'h0D;
    localparam logic [7:0] CHAR_LF    = 8'h0A;
    localparam logic [7:0] CHAR_TAB   = 8'h09;

    // Key label length and quiet counter limit
    localparam logic [3:0] KEY_LEN       = 4'd8;
    localparam logic [7:0] QUIET_MAX     = 8'hFF;
    localparam logic [7:0] TIMEOUT_RESET = 8'd5;

    // Configuration register indexes
    localparam logic REG_MESSAGE_TIMEOUT = 1'b0;

    // One input beat
    typedef struct packed {
        logic       req_type;
        logic [7:0] data_byte;
    } item_t;

    // One result beat
    typedef struct packed {
        event_kind_t event_kind;
        logic [7:0]  event_byte;
    } result_t;

    // Characters of "Checksum"
    function automatic logic [7:0] key_char(input logic [2:0] idx);
        logic [7:0] ch;
        unique case (idx)
            3'd0: ch = 8'h43; // C
            3'd1: ch = 8'h68; // h
            3'd2: ch = 8'h65; // e
            3'd3: ch = 8'h63; // c
            3'd4: ch = 8'h6B; // k
            3'd5: ch = 8'h73; // s
            3'd6: ch = 8'h75; // u
            3'd7: ch = 8'h6D; // m
            default: ch = 8'h00;
        endcase
        return ch;
    endfunction

endpackage

[hw/rtl/tfp_cfg.sv]
// APB register block holding the message timeout.
module tfp_cfg (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    output logic [7:0]  message_timeout
);
    import tfp_pkg::*;

    logic [7:0] timeout_reg;
    logic       wr_en;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite && (paddr[2] == REG_MESSAGE_TIMEOUT);

    // Timeout register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            timeout_reg <= TIMEOUT_RESET;
        end else if (wr_en) begin
            timeout_reg <= pwdata[7:0];
        end
    end

    // Read mux
    always_comb begin
        prdata = '0;
        if (paddr[2] == REG_MESSAGE_TIMEOUT) begin
            prdata = {24'd0, timeout_reg};
        end
    end

    assign message_timeout = timeout_reg;

endmodule

[hw/rtl/tfp_in_reg.sv]
// Input register stage: captures one beat and hands it to the parser.
module tfp_in_reg (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  tfp_pkg::item_t      s_item,
    input  logic                pipe_ready,
    output logic                item_valid,
    output tfp_pkg::item_t      item
);
    import tfp_pkg::*;

    logic  valid_reg;
    item_t item_reg;

    // Free when empty or when the parser takes the held beat this cycle
    assign s_ready = !valid_reg || pipe_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (s_ready) begin
            valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_ready && s_valid) begin
            item_reg <= s_item;
        end
    end

    assign item_valid = valid_reg;
    assign item       = item_reg;

endmodule

[hw/rtl/tfp_parser.sv]
// Frame parser state machine with checksum and timeout, plus the result register.
module tfp_parser (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                item_valid,
    input  tfp_pkg::item_t      item,
    output logic                pipe_ready,
    input  logic [7:0]          message_timeout,
    output logic                m_valid,
    input  logic                m_ready,
    output tfp_pkg::result_t    m_result
);
    import tfp_pkg::*;

    phase_t     phase_reg, phase_next;
    phase_t     resume_reg, resume_next;
    logic [7:0] sum_reg, sum_next;
    logic [3:0] pos_reg, pos_next;
    logic       still_reg, still_next;
    logic [7:0] quiet_reg, quiet_next;

    logic       res_valid_reg;
    result_t    res_reg, res_next;

    logic       step;
    logic [7:0] c;
    logic [7:0] quiet_inc;
    logic [7:0] sum_base;
    logic [7:0] sum_add;

    // Result slot is free when empty or being drained
    assign pipe_ready = !res_valid_reg || m_ready;
    assign step       = item_valid && pipe_ready;
    assign c          = item.data_byte;

    assign quiet_inc = (quiet_reg < QUIET_MAX) ? quiet_reg + 8'd1 : quiet_reg;
    // Sum restarts at the CR that opens a frame
    assign sum_base  = ((phase_reg == PH_IDLE) && (c == CHAR_CR)) ? 8'd0 : sum_reg;
    assign sum_add   = sum_base + c;

    // State registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg  <= PH_IDLE;
            resume_reg <= PH_IDLE;
            sum_reg    <= '0;
            pos_reg    <= '0;
            still_reg  <= 1'b1;
            quiet_reg  <= '0;
        end else if (step) begin
            phase_reg  <= phase_next;
            resume_reg <= resume_next;
            sum_reg    <= sum_next;
            pos_reg    <= pos_next;
            still_reg  <= still_next;
            quiet_reg  <= quiet_next;
        end
    end

    // Next state and event
    always_comb begin
        phase_next  = phase_reg;
        resume_next = resume_reg;
        sum_next    = sum_reg;
        pos_next    = pos_reg;
        still_next  = still_reg;
        quiet_next  = quiet_reg;
        res_next.event_kind = EV_NONE;
        res_next.event_byte = 8'd0;

        if (item.req_type == REQ_TICK) begin
            // Quiet-second tick; idle ignores it
            if (phase_reg != PH_IDLE) begin
                if (quiet_inc >= message_timeout) begin
                    phase_next = PH_IDLE;
                    quiet_next = '0;
                    res_next.event_kind = EV_TIMEOUT;
                end else begin
                    quiet_next = quiet_inc;
                end
            end
        end else begin
            quiet_next = '0;
            if (c == CHAR_COLON && phase_reg != PH_CKSUM) begin
                // Hex record start; nested colons keep the saved phase
                if (phase_reg != PH_HEX) begin
                    resume_next = phase_reg;
                end
                phase_next = PH_HEX;
            end else begin
                unique case (phase_reg)
                    PH_HEX: begin
                        if (c == CHAR_LF) begin
                            phase_next = resume_reg;
                        end
                    end
                    PH_CKSUM: begin
                        sum_next   = sum_add;
                        phase_next = PH_IDLE;
                        res_next.event_kind = (sum_add == 8'd0) ? EV_OK : EV_BAD;
                    end
                    PH_WAIT: begin
                        sum_next = sum_add;
                        if (c == CHAR_LF) begin
                            phase_next = PH_LABEL;
                            pos_next   = '0;
                            still_next = 1'b1;
                        end else begin
                            phase_next = PH_IDLE;
                        end
                    end
                    PH_LABEL: begin
                        sum_next = sum_add;
                        if (c == CHAR_TAB) begin
                            if (still_reg && pos_reg == KEY_LEN) begin
                                phase_next = PH_CKSUM;
                            end else begin
                                phase_next = PH_VALUE;
                                res_next.event_kind = EV_VSTART;
                            end
                        end else begin
                            if (still_reg && pos_reg < KEY_LEN &&
                                c == key_char(pos_reg[2:0])) begin
                                pos_next = pos_reg + 4'd1;
                            end else begin
                                still_next = 1'b0;
                            end
                            res_next.event_kind = EV_LCHAR;
                            res_next.event_byte = c;
                        end
                    end
                    PH_VALUE: begin
                        sum_next = sum_add;
                        if (c == CHAR_CR) begin
                            phase_next = PH_WAIT;
                            res_next.event_kind = EV_FEND;
                        end else begin
                            res_next.event_kind = EV_VCHAR;
                            res_next.event_byte = c;
                        end
                    end
                    default: begin
                        // Idle and unreachable codes
                        sum_next   = sum_add;
                        phase_next = (c == CHAR_CR) ? PH_WAIT : PH_IDLE;
                    end
                endcase
            end
        end
    end

    // Result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            res_valid_reg <= 1'b0;
        end else if (pipe_ready) begin
            res_valid_reg <= item_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (step) begin
            res_reg <= res_next;
        end
    end

    assign m_valid  = res_valid_reg;
    assign m_result = res_reg;

endmodule

[hw/rtl/text_frame_parser_with_checksum_core.sv]
// Top level of the serial text frame parser with 8-bit checksum.
//
//  channel   dir   beat content
//  s_*       in    tuser = req_type, tdata = data_byte
//  m_*       out   tuser = event_kind, tdata = event_byte
//  APB       in    message_timeout at byte address 0
//
//  m_tvalid rises once the result register loads the event of an accepted s_
//  beat: the beat sits in the input register while the parser state machine
//  computes its event, which the result register loads when its slot is free. Throughput
//  is one beat per cycle unless m_tready stalls; the parser state updates once per beat.
//  Reset (aresetn low, synchronous) empties both registers, sets the parser
//  to idle and the timeout to 5 seconds.
//  A stall on m_tready holds the result; s_tready drops only when both stages are full.
module text_frame_parser_with_checksum_core (
    input  logic        aclk,
    input  logic        aresetn,
    // Input beats
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] data_byte
    input  logic        s_tuser,   // [0] req_type
    // Result beats
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata,   // [7:0] event_byte
    output logic [2:0]  m_tuser,   // [2:0] event_kind
    // Configuration
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import tfp_pkg::*;

    item_t      s_item;
    item_t      item;
    logic       item_valid;
    logic       pipe_ready;
    result_t    m_result;
    logic [7:0] message_timeout;

    assign s_item.req_type  = s_tuser;
    assign s_item.data_byte = s_tdata;

    tfp_cfg u_cfg (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .psel            (psel),
        .penable         (penable),
        .pwrite          (pwrite),
        .paddr           (paddr),
        .pwdata          (pwdata),
        .prdata          (prdata),
        .pready          (pready),
        .message_timeout (message_timeout)
    );

    tfp_in_reg u_in_reg (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_tvalid),
        .s_ready    (s_tready),
        .s_item     (s_item),
        .pipe_ready (pipe_ready),
        .item_valid (item_valid),
        .item       (item)
    );

    tfp_parser u_parser (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .item_valid      (item_valid),
        .item            (item),
        .pipe_ready      (pipe_ready),
        .message_timeout (message_timeout),
        .m_valid         (m_tvalid),
        .m_ready         (m_tready),
        .m_result        (m_result)
    );

    assign m_tdata = m_result.event_byte;
    assign m_tuser = m_result.event_kind;

endmodule

[hw/rtl/tfp_checker.sv]
// Port-level checks for the text frame parser core, bound to the top level.
module tfp_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [7:0]  m_tdata,
    input logic [2:0]  m_tuser,
    input logic [31:0] prdata
);
    import tfp_pkg::*;

    // A stalled result beat holds its content
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("result beat changed while stalled");

    // Only character events carry a byte
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser != EV_LCHAR && m_tuser != EV_VCHAR |-> m_tdata == 8'd0)
        else $error("nonzero byte on a non-character event");

    // A draining output never backs up the input
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tready |-> s_tready)
        else $error("input stalled while output is ready");

    // Register reads carry only the 8-bit timeout
    assert property (@(posedge aclk) disable iff (!aresetn)
        prdata[31:8] == 24'd0)
        else $error("upper read data bits set");

endmodule

bind text_frame_parser_with_checksum_core tfp_checker u_tfp_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .prdata   (prdata)
);
